// ===== hw/rtl/pbpd_pkg.sv =====
// Shared constants and types of the planar bitmap palette decoder.
`default_nettype none

package pbpd_pkg;

   localparam int GROUP_BITS = 8;
   localparam int REQ_DATA_WIDTH = 96;
   localparam int RSP_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [7:0] FULL_ALPHA = 8'hFF;

   // item kind carried in req_tuser
   localparam logic MODE_PALETTE = 1'b0;
   localparam logic MODE_PIXELS = 1'b1;

   // register indexes, taken from csr_paddr[3:2]
   typedef enum logic [1:0] {
      REG_PLANE_COUNT = 2'd0,
      REG_PALETTE_COLORS = 2'd1,
      REG_IMAGE_WIDTH = 2'd2,
      REG_UNUSED = 2'd3
   } reg_index_type;

   // per-pixel flags that follow a palette read
   typedef struct packed {
      logic hit;
      logic last;
   } pix_meta_type;

endpackage

`default_nettype wire

// ===== hw/rtl/planar_bitmap_palette_decoder_unit.sv =====
// Top level of the planar bitmap palette decoder: bitplane groups in, RGBA pixels out.
//
// req channel: one word per item. tuser selects the kind: a palette word writes one
// 24-bit color into the palette RAM and gives no result; a pixel word brings the byte
// at one offset of each bitplane and gives one rsp word per pixel, MSB first, up to
// eight, fewer at the end of a row (cut at image_width). tlast marks a group's last.
// rsp channel: red, green, blue, alpha; alpha is 255 for an index below
// palette_colors, else the pixel is all zero.
// The first pixel of a group passes the issue stage, the palette RAM's read
// register and the output register. Throughput: one rsp pixel per cycle while
// rsp_tready lets the pipeline move, set by the single palette read port.
// The next word is taken in the cycle the current one issues its last read.
// Reset clears the pipeline valids, the column position and the registers to
// plane_count 1, palette_colors 0, image_width 8; the palette RAM is not cleared
// and must be written before its entries are used.
// When rsp_tready is low the output word holds and the pipeline behind it fills
// and then stops; req_tready drops once the issue stage cannot advance.
`default_nettype none

module planar_bitmap_palette_decoder_unit #(
   parameter int MAX_PLANES = 8,
   parameter int PALETTE_DEPTH = 256
) (
   input  wire         clock,
   input  wire         reset,
   // req_tdata, low bit up: plane_byte_0 .. plane_byte_7, palette_index, palette_rgb
   input  wire  [95:0] req_tdata,
   // req_tuser: mode
   input  wire  [0:0]  req_tuser,
   input  wire         req_tvalid,
   output logic        req_tready,
   // rsp_tdata, low bit up: red, green, blue, alpha
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [3:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(PALETTE_DEPTH);

   // configuration
   logic [3:0]  plane_count_ff, plane_count_in;
   logic [8:0]  palette_colors_ff, palette_colors_in;
   logic [15:0] image_width_ff, image_width_in;
   logic        csr_write;
   pbpd_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite;
   assign csr_index = pbpd_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      plane_count_in = plane_count_ff;
      palette_colors_in = palette_colors_ff;
      image_width_in = image_width_ff;
      csr_prdata = '0;
      case (csr_index)
         pbpd_pkg::REG_PLANE_COUNT: begin
            csr_prdata = {28'd0, plane_count_ff};
            if (csr_write) plane_count_in = csr_pwdata[3:0];
         end
         pbpd_pkg::REG_PALETTE_COLORS: begin
            csr_prdata = {23'd0, palette_colors_ff};
            if (csr_write) palette_colors_in = csr_pwdata[8:0];
         end
         pbpd_pkg::REG_IMAGE_WIDTH: begin
            csr_prdata = {16'd0, image_width_ff};
            if (csr_write) image_width_in = csr_pwdata[15:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // row position and group length at accept
   logic [15:0] column_ff, column_in;
   logic [16:0] width_eff, start_col, remain, next_col;
   logic [3:0]  group_count;
   logic [3:0]  planes_eff;
   logic        req_accept;

   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      width_eff = (image_width_ff == 16'd0) ? 17'h10000 : {1'b0, image_width_ff};
      start_col = ({1'b0, column_ff} >= width_eff) ? 17'd0 : {1'b0, column_ff};
      remain = width_eff - start_col;
      group_count = (remain > 17'(pbpd_pkg::GROUP_BITS)) ?
                    4'(pbpd_pkg::GROUP_BITS) : remain[3:0];
      next_col = start_col + {13'd0, group_count};
      if (next_col >= width_eff) next_col = 17'd0;
      column_in = column_ff;
      if (req_accept && req_tuser[0] == pbpd_pkg::MODE_PIXELS) column_in = next_col[15:0];

      if (plane_count_ff == 4'd0) planes_eff = 4'd1;
      else if (plane_count_ff > 4'(MAX_PLANES)) planes_eff = 4'(MAX_PLANES);
      else planes_eff = plane_count_ff;
   end

   // issue stage: one palette write or one palette read per cycle, a read only while the read stage can move
   logic        s_vld_ff, s_vld_in;
   logic        s_mode_ff, s_mode_in;
   logic [3:0]  s_left_ff, s_left_in;
   logic [7:0]  s_bytes_ff [MAX_PLANES];
   logic [7:0]  s_bytes_in [MAX_PLANES];
   logic [7:0]  s_index_ff, s_index_in;
   logic [23:0] s_rgb_ff, s_rgb_in;

   // read stage and output register
   logic                   r_vld_ff, r_vld_in;
   pbpd_pkg::pix_meta_type r_meta_ff, r_meta_in;
   logic                   o_vld_ff, o_vld_in;
   logic [31:0]            o_data_ff, o_data_in;
   logic                   o_last_ff, o_last_in;

   logic                   o_free, r_move, s_fire, s_read, s_done;
   logic [MAX_PLANES-1:0]  cidx;
   logic [8:0]             cidx_wide;
   logic [8:0]             wr_index_wide;
   logic                   ram_we;
   logic [23:0]            ram_rdata;

   always_comb begin
      for (int p = 0; p < MAX_PLANES; p++) begin
         cidx[p] = s_bytes_ff[p][7];
      end
      cidx_wide = 9'(cidx);
      wr_index_wide = {1'b0, s_index_ff};
   end

   assign o_free = ~o_vld_ff | rsp_tready;
   assign r_move = r_vld_ff & o_free;
   assign s_fire = s_vld_ff & ((s_mode_ff == pbpd_pkg::MODE_PALETTE) | ~r_vld_ff | r_move);
   assign s_read = s_fire & (s_mode_ff == pbpd_pkg::MODE_PIXELS);
   assign s_done = s_fire & ((s_mode_ff == pbpd_pkg::MODE_PALETTE) | (s_left_ff == 4'd1));
   assign req_tready = ~s_vld_ff | s_done;
   assign ram_we = s_fire & (s_mode_ff == pbpd_pkg::MODE_PALETTE) &
                   (wr_index_wide < 9'(PALETTE_DEPTH));

   always_comb begin
      s_vld_in = s_vld_ff;
      s_mode_in = s_mode_ff;
      s_left_in = s_left_ff;
      s_index_in = s_index_ff;
      s_rgb_in = s_rgb_ff;
      s_bytes_in = s_bytes_ff;
      if (s_read) begin
         s_left_in = s_left_ff - 4'd1;
         for (int p = 0; p < MAX_PLANES; p++) begin
            s_bytes_in[p] = {s_bytes_ff[p][6:0], 1'b0};
         end
      end
      if (s_done) s_vld_in = 1'b0;
      if (req_accept) begin
         s_vld_in = 1'b1;
         s_mode_in = req_tuser[0];
         s_left_in = group_count;
         s_index_in = req_tdata[71:64];
         s_rgb_in = req_tdata[95:72];
         // drop the bytes of unused planes
         for (int p = 0; p < MAX_PLANES; p++) begin
            s_bytes_in[p] = (4'(p) < planes_eff) ? req_tdata[8*p +: 8] : 8'd0;
         end
      end

      r_vld_in = r_vld_ff;
      r_meta_in = r_meta_ff;
      if (r_move) r_vld_in = 1'b0;
      if (s_read) begin
         r_vld_in = 1'b1;
         r_meta_in.hit = (cidx_wide < palette_colors_ff) & (cidx_wide < 9'(PALETTE_DEPTH));
         r_meta_in.last = (s_left_ff == 4'd1);
      end

      o_vld_in = o_vld_ff;
      o_data_in = o_data_ff;
      o_last_in = o_last_ff;
      if (o_vld_ff && rsp_tready) o_vld_in = 1'b0;
      if (r_move) begin
         o_vld_in = 1'b1;
         o_last_in = r_meta_ff.last;
         if (r_meta_ff.hit) begin
            o_data_in = {pbpd_pkg::FULL_ALPHA, ram_rdata[7:0], ram_rdata[15:8],
                         ram_rdata[23:16]};
         end else begin
            o_data_in = '0;
         end
      end
   end

   pbpd_ram #(
      .WIDTH(24),
      .DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_index_wide[AW-1:0]),
      .wdata (s_rgb_ff),
      .re    (s_read),
      .raddr (cidx_wide[AW-1:0]),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff <= 4'd1;
         palette_colors_ff <= 9'd0;
         image_width_ff <= 16'd8;
         column_ff <= 16'd0;
         s_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         plane_count_ff <= plane_count_in;
         palette_colors_ff <= palette_colors_in;
         image_width_ff <= image_width_in;
         column_ff <= column_in;
         s_vld_ff <= s_vld_in;
         r_vld_ff <= r_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s_mode_ff <= s_mode_in;
      s_left_ff <= s_left_in;
      s_index_ff <= s_index_in;
      s_rgb_ff <= s_rgb_in;
      s_bytes_ff <= s_bytes_in;
      r_meta_ff <= r_meta_in;
      o_data_ff <= o_data_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata = o_data_ff;
   assign rsp_tlast = o_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pbpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pbpd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire                     clock,
   input  wire                     we,
   input  wire [$clog2(DEPTH)-1:0] waddr,
   input  wire [WIDTH-1:0]         wdata,
   input  wire                     re,
   input  wire [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire
